// ===== hw/rtl/ps2fr_pkg.sv =====
// Shared types and constants of the PS/2 frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package ps2fr_pkg;

   // Request opcodes.
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_EDGE = 1'b1;

   // Bit position codes within a frame.
   localparam logic [3:0] POS_START     = 4'd0;
   localparam logic [3:0] POS_DATA_LAST = 4'd8;
   localparam logic [3:0] POS_PARITY    = 4'd9;
   localparam logic [3:0] POS_STOP      = 4'd10;

   // Timeout register reset value and the saturation point of the tick counter.
   localparam logic [15:0] TIMEOUT_RESET = 16'd12000;
   localparam logic [16:0] ELAPSED_MAX   = 17'h1FFFF;

   // One request item.
   typedef struct packed {
      logic op;
      logic data_bit;
   } item_type;

   // Outcome of handling one request.
   typedef struct packed {
      logic       emit;
      logic [7:0] scan_code;
   } step_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ps2fr_if.sv =====
// Handshake interfaces for the request and response channels.
`timescale 1ns / 1ps
`default_nettype none

interface ps2fr_req_if;
   logic valid;
   logic ready;
   logic op;
   logic data_bit;

   modport source (output valid, output op, output data_bit, input ready);
   modport sink (input valid, input op, input data_bit, output ready);
endinterface

interface ps2fr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] scan_code;

   modport source (output valid, output scan_code, input ready);
   modport sink (input valid, input scan_code, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ps2fr_frame_engine.sv =====
// Frame state registers and the per-request update logic.
`timescale 1ns / 1ps
`default_nettype none

module ps2fr_frame_engine (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  step_en,
   input  ps2fr_pkg::item_type  item,
   input  wire [15:0]           timeout_ticks,
   output ps2fr_pkg::step_type  step
);

   logic [3:0]  bit_position_ff;
   logic [3:0]  bit_position_in;
   logic [8:0]  frame_shift_ff;
   logic [8:0]  frame_shift_in;
   logic [16:0] elapsed_ff;
   logic [16:0] elapsed_in;
   logic        timed_out;
   logic [2:0]  data_index;
   logic [8:0]  data_merged;
   logic [8:0]  parity_merged;

   // Gap check and the frame word with the current bit merged in.
   always_comb begin
      timed_out     = elapsed_ff > {1'b0, timeout_ticks};
      data_index    = 3'(bit_position_ff - 4'd1);
      data_merged   = frame_shift_ff | (9'(item.data_bit) << data_index);
      parity_merged = {item.data_bit, frame_shift_ff[7:0]};
   end

   // Next state and result for one request.
   always_comb begin
      bit_position_in = bit_position_ff;
      frame_shift_in  = frame_shift_ff;
      elapsed_in      = elapsed_ff;
      step.emit       = 1'b0;
      step.scan_code  = frame_shift_ff[7:0];
      if (item.op == ps2fr_pkg::OP_TICK) begin
         if (elapsed_ff != ps2fr_pkg::ELAPSED_MAX) begin
            elapsed_in = elapsed_ff + 17'd1;
         end
      end else if (bit_position_ff == ps2fr_pkg::POS_START) begin
         // A start bit must be low; a high level is ignored.
         if (!item.data_bit) begin
            bit_position_in = 4'd1;
            frame_shift_in  = '0;
            elapsed_in      = '0;
         end
      end else if (timed_out) begin
         bit_position_in = ps2fr_pkg::POS_START;
         frame_shift_in  = '0;
         elapsed_in      = '0;
      end else if (bit_position_ff <= ps2fr_pkg::POS_DATA_LAST) begin
         bit_position_in = bit_position_ff + 4'd1;
         frame_shift_in  = data_merged;
         elapsed_in      = '0;
      end else if (bit_position_ff == ps2fr_pkg::POS_PARITY) begin
         // Odd parity over data and parity bits.
         if (^parity_merged) begin
            bit_position_in = ps2fr_pkg::POS_STOP;
            frame_shift_in  = parity_merged;
            elapsed_in      = '0;
         end else begin
            bit_position_in = ps2fr_pkg::POS_START;
            frame_shift_in  = '0;
            elapsed_in      = '0;
         end
      end else begin
         // Stop bit: a high level completes the frame.
         step.emit       = item.data_bit;
         bit_position_in = ps2fr_pkg::POS_START;
         frame_shift_in  = '0;
         elapsed_in      = '0;
      end
   end

   // State registers update only when a request is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_position_ff <= ps2fr_pkg::POS_START;
         frame_shift_ff  <= '0;
         elapsed_ff      <= '0;
      end else if (step_en) begin
         bit_position_ff <= bit_position_in;
         frame_shift_ff  <= frame_shift_in;
         elapsed_ff      <= elapsed_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ps2_frame_receiver_core.sv =====
// Top level of the PS/2 frame receiver: request register, frame engine, response register.
//
//   Channel | Direction | Payload               | Handshake
//   req     | in        | op, data_bit          | valid / ready
//   rsp     | out       | scan_code [7:0]       | valid / ready
//   csr     | in        | timeout_ticks [15:0]  | write enable only
//
// A request is held in the request register while the frame engine
// evaluates it; its scan code, if any, is loaded into the response register
// when the request moves on.
// One request is accepted every cycle while the response side is not stalled.
// A stalled response only holds back a request that completes a frame.
// Reset is synchronous and clears the frame state and both valid flags; the
// timeout register returns to 12000 ticks.
`timescale 1ns / 1ps
`default_nettype none

module ps2_frame_receiver_core (
   input  wire        clock,
   input  wire        reset,
   ps2fr_req_if.sink  req_port,
   ps2fr_rsp_if.source rsp_port,
   input  wire        csr_write_enable,
   input  wire [15:0] csr_write_data
);

   logic                in_valid_ff;
   ps2fr_pkg::item_type in_item_ff;
   logic                out_valid_ff;
   logic [7:0]          out_code_ff;
   logic [15:0]         timeout_ff;
   ps2fr_pkg::step_type step;
   logic                advance;
   logic                req_take;

   // The held request moves on unless it produces a byte the output cannot take.
   assign advance  = in_valid_ff && (!step.emit || !out_valid_ff || rsp_port.ready);
   assign req_port.ready = !in_valid_ff || advance;
   assign req_take = req_port.valid && req_port.ready;

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_port.ready) begin
         in_valid_ff <= req_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.op       <= req_port.op;
         in_item_ff.data_bit <= req_port.data_bit;
      end
   end

   // Timeout configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= ps2fr_pkg::TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         timeout_ff <= csr_write_data;
      end
   end

   ps2fr_frame_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .item          (in_item_ff),
      .timeout_ticks (timeout_ff),
      .step          (step)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && step.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step.emit) begin
         out_code_ff <= step.scan_code;
      end
   end

   assign rsp_port.valid     = out_valid_ff;
   assign rsp_port.scan_code = out_code_ff;

endmodule

`default_nettype wire

// ===== verif/ps2fr_checker.sv =====
// Scoreboard for the PS/2 frame receiver: predicts scan codes and checks the response channel.
`timescale 1ns / 1ps

module ps2fr_checker (
   input  wire        clock,
   input  wire        reset,
   ps2fr_req_if       req_bus,
   ps2fr_rsp_if       rsp_bus,
   input  wire        csr_write_enable,
   input  wire [15:0] csr_write_data,
   output int         fail_count,
   output int         codes_outstanding
);

   // Predicted frame state and the timeout register copy.
   logic [3:0]  bit_pos;
   logic [8:0]  frame_bits;
   logic [16:0] ticks_since_edge;
   logic [15:0] timeout_limit;

   // Scan codes predicted but not yet seen on the response channel.
   logic [7:0]  expected_codes[$];
   int          mismatches = 0;

   task automatic clear_frame();
      bit_pos = ps2fr_pkg::POS_START;
      frame_bits = '0;
      ticks_since_edge = '0;
   endtask

   // Advances the predicted frame state by one request.
   task automatic decode_request(input logic op, input logic d,
                                 output logic emit, output logic [7:0] code);
      emit = 1'b0;
      code = '0;
      if (op == ps2fr_pkg::OP_TICK) begin
         // The gap counter stops at its maximum instead of wrapping.
         if (ticks_since_edge != ps2fr_pkg::ELAPSED_MAX) begin
            ticks_since_edge = ticks_since_edge + 17'd1;
         end
      end else if (bit_pos == ps2fr_pkg::POS_START) begin
         // A high level while waiting for a start bit is ignored entirely.
         if (!d) begin
            bit_pos = 4'd1;
            frame_bits = '0;
            ticks_since_edge = '0;
         end
      end else if (ticks_since_edge > {1'b0, timeout_limit}) begin
         clear_frame();
      end else if (bit_pos <= ps2fr_pkg::POS_DATA_LAST) begin
         frame_bits[bit_pos - 4'd1] = d;
         bit_pos = bit_pos + 4'd1;
         ticks_since_edge = '0;
      end else if (bit_pos == ps2fr_pkg::POS_PARITY) begin
         frame_bits[8] = d;
         if (^frame_bits) begin
            bit_pos = ps2fr_pkg::POS_STOP;
            ticks_since_edge = '0;
         end else begin
            clear_frame();
         end
      end else begin
         // Stop bit, or any position beyond it.
         if (d) begin
            emit = 1'b1;
            code = frame_bits[7:0];
         end
         clear_frame();
      end
   endtask

   // Check responses first, then apply register writes and new requests.
   always @(posedge clock) begin
      logic       emit_now;
      logic [7:0] code_now;
      logic [7:0] want;
      if (reset) begin
         clear_frame();
         timeout_limit = ps2fr_pkg::TIMEOUT_RESET;
         expected_codes.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_codes.size() == 0) begin
               $error("scan_code: expected none, actual 0x%02h", rsp_bus.scan_code);
               mismatches++;
            end else begin
               want = expected_codes.pop_front();
               if (rsp_bus.scan_code !== want) begin
                  $error("scan_code: expected 0x%02h, actual 0x%02h", want,
                         rsp_bus.scan_code);
                  mismatches++;
               end
            end
         end
         if (csr_write_enable) begin
            timeout_limit = csr_write_data;
         end
         if (req_bus.valid && req_bus.ready) begin
            decode_request(req_bus.op, req_bus.data_bit, emit_now, code_now);
            if (emit_now) begin
               expected_codes.push_back(code_now);
            end
         end
      end
      fail_count <= mismatches;
      codes_outstanding <= expected_codes.size();
   end

endmodule

// ===== verif/tb_top.sv =====
// Top of the PS/2 frame receiver testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;
   logic        idle_enable;
   int          fail_count;
   int          codes_outstanding;
   int          items_sent = 0;
   int          timeout_now = ps2fr_pkg::TIMEOUT_RESET;

   ps2fr_req_if req_bus ();
   ps2fr_rsp_if rsp_bus ();

   ps2_frame_receiver_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_bus),
      .rsp_port         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   ps2fr_checker scan_checker (
      .clock             (clock),
      .reset             (reset),
      .req_bus           (req_bus),
      .rsp_bus           (rsp_bus),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .fail_count        (fail_count),
      .codes_outstanding (codes_outstanding)
   );

   // 10 ns clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // The response side stalls at random while idling is enabled.
   always @(posedge clock) begin
      rsp_bus.ready <= !idle_enable || ($urandom_range(0, 99) >= 28);
   end

   // Hard limit on the run.
   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   // Sends one request, with random idle cycles ahead of it.
   task automatic send_request(input logic op, input logic d);
      while (idle_enable && $urandom_range(0, 99) < 28) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op <= op;
      req_bus.data_bit <= d;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   // Timer ticks; the data level is don't-care here, so it is randomized.
   task automatic tick_run(input int count);
      repeat (count) send_request(ps2fr_pkg::OP_TICK, 1'($urandom_range(0, 1)));
   endtask

   // One frame with random tick gaps between bits, optionally corrupted.
   task automatic send_frame(input logic [7:0] code, input logic bad_parity,
                             input logic stop_level, input int gap_max);
      logic [10:0] bits;
      bits = {stop_level, (~^code) ^ bad_parity, code, 1'b0};
      for (int i = 0; i < 11; i++) begin
         if (i != 0) begin
            tick_run($urandom_range(0, gap_max));
         end
         send_request(ps2fr_pkg::OP_EDGE, bits[i]);
      end
   endtask

   // Stops requests and waits until every predicted scan code has come back.
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      for (int n = 0; n < 5000 && codes_outstanding != 0; n++) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      timeout_now = value;
   endtask

   // Mostly well-formed frames, with corrupted frames, stray edges and ticks mixed in.
   task automatic random_traffic(input int budget);
      int stop_at;
      int pick;
      int gap_max;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         gap_max = (timeout_now < 4) ? timeout_now : 4;
         if (timeout_now <= 40 && $urandom_range(0, 7) == 0) begin
            gap_max = timeout_now + 2;
         end
         if (pick < 70) begin
            send_frame(8'($urandom), 1'b0, 1'b1, gap_max);
         end else if (pick < 78) begin
            send_frame(8'($urandom), 1'b1, 1'b1, gap_max);
         end else if (pick < 86) begin
            send_frame(8'($urandom), 1'b0, 1'b0, gap_max);
         end else if (pick < 93) begin
            send_request(ps2fr_pkg::OP_EDGE, 1'($urandom_range(0, 1)));
         end else begin
            tick_run($urandom_range(1, 6));
         end
      end
   endtask

   initial begin
      int          phase;
      int          random_base;
      logic [15:0] setting;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.op <= ps2fr_pkg::OP_TICK;
      req_bus.data_bit <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      idle_enable = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed frames at the reset timeout, without idling.
      send_request(ps2fr_pkg::OP_EDGE, 1'b1);
      tick_run(2);
      send_frame(8'hFF, 1'b0, 1'b1, 1);
      send_frame(8'h00, 1'b1, 1'b1, 0);
      send_frame(8'h5A, 1'b0, 1'b0, 0);
      send_frame(8'h00, 1'b0, 1'b1, 0);

      // A gap just over a short timeout drops the first data bit.
      write_timeout(16'd3);
      send_request(ps2fr_pkg::OP_EDGE, 1'b0);
      tick_run(4);
      send_request(ps2fr_pkg::OP_EDGE, 1'b1);
      send_frame(8'hA5, 1'b0, 1'b1, 3);

      // Zero timeout: any tick between bits restarts the frame.
      write_timeout(16'h0000);
      send_frame(8'h3C, 1'b0, 1'b1, 0);
      send_frame(8'hC3, 1'b0, 1'b1, 1);

      // Largest timeout.
      write_timeout(16'hFFFF);
      send_frame(8'h81, 1'b0, 1'b1, 3);

      // Random phases, each under its own timeout; one phase in four runs without idling.
      random_base = items_sent;
      phase = 0;
      while (items_sent - random_base < 1100) begin
         case (phase % 5)
            0: setting = 16'd1;
            1: setting = 16'($urandom_range(2, 8));
            2: setting = 16'($urandom_range(9, 40));
            3: setting = 16'($urandom_range(41, 65535));
            default: setting = 16'd0;
         endcase
         write_timeout(setting);
         idle_enable = (phase % 4 != 2);
         random_traffic(200);
         phase++;
      end

      settle();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && codes_outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== ps2_frame_receiver_core.f =====
hw/rtl/ps2fr_pkg.sv
hw/rtl/ps2fr_if.sv
hw/rtl/ps2fr_frame_engine.sv
hw/rtl/ps2_frame_receiver_core.sv
verif/ps2fr_checker.sv
verif/tb_top.sv
